// ----- rtl/bed_pkg.sv -----
// Shared types, character constants and escape classification functions.
`default_nettype none

package bed_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_HEX_MARK  = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_OCT_MAX   = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] CH_LC_F      = 8'h66;
    localparam logic [7:0] CH_UC_A      = 8'h41;
    localparam logic [7:0] CH_UC_F      = 8'h46;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_PREFIX,
        CLS_FULL
    } esc_class_t;

    // Results of one input word, oldest in bytes[0].
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            last;
    } group_t;

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_OCT_MAX);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
               ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
               ((c >= CH_UC_A) && (c <= CH_UC_F));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c <= CH_NINE)
            v = c - CH_ZERO;
        else if (c >= CH_LC_A)
            v = c - CH_LC_A + 8'd10;
        else
            v = c - CH_UC_A + 8'd10;
        return v[3:0];
    endfunction

    // p[0] is the first byte, len (1..4) the number of valid bytes.
    function automatic esc_class_t classify(input logic [3:0][7:0] p, input logic [2:0] len);
        logic oct;
        logic ok;
        oct = is_oct(p[1]);
        ok  = 1'b1;
        if (len > 3'd2)
            ok = ok && (oct ? is_oct(p[2]) : is_hex(p[2]));
        if (len > 3'd3)
            ok = ok && (oct ? is_oct(p[3]) : is_hex(p[3]));
        if (p[0] != CH_BACKSLASH)
            return CLS_NONE;
        else if (len < 3'd2)
            return CLS_PREFIX;
        else if (!oct && (p[1] != CH_HEX_MARK))
            return CLS_NONE;
        else if (!ok)
            return CLS_NONE;
        else if (len == 3'd4)
            return CLS_FULL;
        else
            return CLS_PREFIX;
    endfunction

    // Octal weights 64/8/1 mod 256 reduce to a bit concatenation.
    function automatic logic [7:0] decode(input logic [3:0][7:0] p);
        if (p[1] == CH_HEX_MARK)
            return {hex_val(p[2]), hex_val(p[3])};
        else
            return {p[1][1:0], p[2][2:0], p[3][2:0]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bed_fifo.sv -----
// Small register FIFO with show-ahead read.
`default_nettype none

module bed_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

// ----- rtl/bed_front.sv -----
// Front end: holds the pending escape prefix and turns each word into a result group.
`default_nettype none

module bed_front
    import bed_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output group_t          grp,
    output logic            grp_valid
);

    logic [2:0][7:0] pend_reg, pend_next;
    logic [1:0]      pcnt_reg, pcnt_next;

    logic [3:0][7:0] buf_v;
    logic [3:0][7:0] sh;
    logic [3:0][7:0] rem;
    logic [2:0]      n;
    logic [2:0]      start;
    logic [2:0]      emitted;
    logic [2:0]      len;
    logic            done;
    logic            flush;
    esc_class_t      cls;

    always_comb
    begin
        buf_v[0] = (pcnt_reg > 2'd0) ? pend_reg[0] : in_byte;
        buf_v[1] = (pcnt_reg > 2'd1) ? pend_reg[1] : in_byte;
        buf_v[2] = (pcnt_reg > 2'd2) ? pend_reg[2] : in_byte;
        buf_v[3] = in_byte;
        n        = {1'b0, pcnt_reg} + 3'd1;

        start     = '0;
        emitted   = '0;
        done      = 1'b0;
        flush     = 1'b0;
        sh        = '0;
        len       = '0;
        cls       = CLS_NONE;
        grp.bytes = '0;

        // Greedy rescan; each pass consumes one byte or one whole escape.
        for (int it = 0; it < 4; it++)
        begin
            if (!done && (start < n))
            begin
                sh  = buf_v >> {start, 3'b000};
                len = n - start;
                cls = flush ? CLS_NONE : classify(sh, len);
                case (cls)
                    CLS_FULL:
                    begin
                        grp.bytes[emitted[1:0]] = decode(sh);
                        emitted = emitted + 3'd1;
                        start   = start + 3'd4;
                    end
                    CLS_PREFIX:
                    begin
                        if (in_last)
                        begin
                            // end of string: rest goes out raw
                            flush = 1'b1;
                            grp.bytes[emitted[1:0]] = sh[0];
                            emitted = emitted + 3'd1;
                            start   = start + 3'd1;
                        end
                        else
                            done = 1'b1;
                    end
                    default:
                    begin
                        grp.bytes[emitted[1:0]] = sh[0];
                        emitted = emitted + 3'd1;
                        start   = start + 3'd1;
                    end
                endcase
            end
        end

        grp.count = emitted;
        grp.last  = in_last;
        grp_valid = accept && (emitted != 3'd0);

        rem          = buf_v >> {start, 3'b000};
        pend_next[0] = rem[0];
        pend_next[1] = rem[1];
        pend_next[2] = rem[2];
        len          = n - start;
        pcnt_next    = in_last ? 2'd0 : len[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pcnt_reg <= '0;
        else if (accept)
            pcnt_reg <= pcnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// ----- rtl/bed_back.sv -----
// Back end: serializes queued result groups one byte per cycle while the output queue is not full.
`default_nettype none

module bed_back
    import bed_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire group_t grp,
    input  wire logic   grp_empty,
    output logic        grp_pop,
    input  wire logic   out_full,
    output logic        out_push,
    output logic [8:0]  out_word
);

    logic [1:0] idx_reg, idx_next;
    logic       at_end;

    always_comb
    begin
        at_end   = ({1'b0, idx_reg} == (grp.count - 3'd1));
        out_push = !grp_empty && !out_full;
        out_word = {grp.last && at_end, grp.bytes[idx_reg]};
        grp_pop  = out_push && at_end;
        idx_next = idx_reg;
        if (out_push)
            idx_next = at_end ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

// ----- rtl/backslash_escape_decoder.sv -----
// Top level of the backslash escape decoder.
//
// Input side is a queue write port: a word (in_byte, in_last) is taken at a
// clock edge with push high and full low. in_last marks the final byte of a
// string. Result side is a queue read port: while empty is low, out_byte and
// out_last show the oldest result; pop with empty low takes it.
// "\ooo" (octal, wraps mod 256) and "\xhh" (hex, either case) collapse to one
// byte; anything else passes through. Up to three bytes of a partial escape
// are held; at end of string they are sent raw and out_last marks the last
// result of that string.
// A word's first result passes the group queue and then the output queue before it
// shows. Throughput: one input word per cycle while full is low; a word yields 0 to
// 4 results, and the serializer drains one result per cycle while the output queue
// is not full, so GRP_DEPTH groups absorb bursts. full rises only when the group
// queue is full. Reset clears the pending prefix and both queues; no result is lost
// or repeated while the receiver stalls, it simply backs up into full.
`default_nettype none

module backslash_escape_decoder
    import bed_pkg::*;
#(
    parameter int GRP_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    group_t     grp_wr;
    group_t     grp_rd;
    logic       grp_valid;
    logic       grp_full;
    logic       grp_empty;
    logic       grp_pop;
    logic       accept;
    logic       out_full;
    logic       out_push;
    logic [8:0] out_word;
    logic [8:0] out_data;

    assign full     = grp_full;
    assign accept   = push && !grp_full;
    assign out_byte = out_data[7:0];
    assign out_last = out_data[8];

    bed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .grp       (grp_wr),
        .grp_valid (grp_valid)
    );

    bed_fifo #(
        .WIDTH ($bits(group_t)),
        .DEPTH (GRP_DEPTH)
    ) u_grp_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (grp_valid),
        .wdata (grp_wr),
        .full  (grp_full),
        .pop   (grp_pop),
        .rdata (grp_rd),
        .empty (grp_empty)
    );

    bed_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp_rd),
        .grp_empty (grp_empty),
        .grp_pop   (grp_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_word  (out_word)
    );

    bed_fifo #(
        .WIDTH (9),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_word),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_data),
        .empty (empty)
    );

endmodule

`default_nettype wire

// ----- tb/backslash_escape_decoder_tb.sv -----
// Self-checking testbench for the backslash escape decoder.
`timescale 1ns / 100ps

module backslash_escape_decoder_tb;
    import bed_pkg::*;

    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam int         RANDOM   = 254;
    localparam int         IDLE_MAX = 4000;
    localparam int         TAIL     = 20;

    typedef struct packed {
        logic [7:0] val;
        logic       eos;
    } dec_word_t;

    typedef enum int {
        TOK_OCT,
        TOK_HEX,
        TOK_BROKEN,
        TOK_RAW,
        TOK_SLASH
    } token_t;

    typedef enum int {
        DRAIN_FULL,
        DRAIN_COIN,
        DRAIN_TRICKLE,
        DRAIN_BEAT
    } drain_mode_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       push     = 1'b0;
    logic [7:0] in_byte  = 8'h00;
    logic       in_last  = 1'b0;
    logic       pop      = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       out_last;

    dec_word_t   stim_q[$];
    dec_word_t   decoded_q[$];
    logic [7:0]  held[3];
    int          held_n      = 0;
    int          errors      = 0;
    int          idle_cycles = 0;
    bit          in_acc      = 1'b0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          pace_left   = 0;
    drain_mode_t pace_mode   = DRAIN_FULL;
    int          beat        = 0;

    backslash_escape_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .out_last (out_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit octal_ch(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_OCT_MAX);
    endfunction

    // 16 means not a hex digit
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c) - int'(CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F)
            return int'(c) - int'(CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F)
            return int'(c) - int'(CH_UC_A) + 10;
        return 16;
    endfunction

    function automatic esc_class_t scan_prefix(input logic [0:3][7:0] seq, input int s,
                                               input int len);
        bit octal;
        int i;
        if (seq[s] != CH_BACKSLASH)
            return CLS_NONE;
        if (len < 2)
            return CLS_PREFIX;
        if (octal_ch(seq[s+1]))
            octal = 1'b1;
        else if (seq[s+1] == CH_HEX_MARK)
            octal = 1'b0;
        else
            return CLS_NONE;
        for (i = 2; i < len; i++)
        begin
            if (octal ? !octal_ch(seq[s+i]) : (nibble_of(seq[s+i]) > 15))
                return CLS_NONE;
        end
        return (len == 4) ? CLS_FULL : CLS_PREFIX;
    endfunction

    function automatic logic [7:0] escape_value(input logic [0:3][7:0] seq, input int s);
        int v;
        if (seq[s+1] == CH_HEX_MARK)
            v = nibble_of(seq[s+2]) * 16 + nibble_of(seq[s+3]);
        else
            v = (int'(seq[s+1]) - int'(CH_ZERO)) * 64 + (int'(seq[s+2]) - int'(CH_ZERO)) * 8
                + (int'(seq[s+3]) - int'(CH_ZERO));
        return v[7:0];
    endfunction

    // Greedy left-to-right unescape of held prefix plus the new byte.
    task automatic unescape_word(input logic [7:0] b, input logic eos);
        logic [0:3][7:0] seq;
        logic [7:0]      res[4];
        int              cnt;
        int              n;
        int              s;
        int              k;
        bit              stop;
        esc_class_t      c;
        dec_word_t       d;
        seq = '0;
        cnt = 0;
        for (k = 0; k < held_n; k++)
            seq[k] = held[k];
        seq[held_n] = b;
        n = held_n + 1;
        s = 0;
        stop = 1'b0;
        while (s < n && !stop)
        begin
            c = scan_prefix(seq, s, n - s);
            if (c == CLS_FULL)
            begin
                res[cnt] = escape_value(seq, s);
                cnt++;
                s += 4;
            end
            else if (c == CLS_PREFIX)
                stop = 1'b1;
            else
            begin
                res[cnt] = seq[s];
                cnt++;
                s++;
            end
        end
        if (eos)
        begin
            while (s < n)
            begin
                res[cnt] = seq[s];
                cnt++;
                s++;
            end
            held_n = 0;
        end
        else
        begin
            for (k = 0; k < n - s; k++)
                held[k] = seq[s+k];
            held_n = n - s;
        end
        for (k = 0; k < cnt; k++)
        begin
            d.val     = res[k];
            d.eos     = eos && (k == cnt - 1);
            decoded_q = {decoded_q, d};
        end
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10)
            return CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] oct_char();
        return CH_ZERO + 8'($urandom_range(0, 7));
    endfunction

    task automatic queue_string(input logic [7:0] str[$]);
        int        i;
        dec_word_t d;
        for (i = 0; i < str.size(); i++)
        begin
            d.val  = str[i];
            d.eos  = (i == str.size() - 1);
            stim_q = {stim_q, d};
        end
    endtask

    // Mostly escape-rich strings; the rest plain noise.
    task automatic queue_random_string();
        logic [7:0] str[$];
        logic [7:0] esc[$];
        int         tokens;
        int         t;
        int         cut;
        token_t     kind;
        str = {};
        if ($urandom_range(0, 4) == 0)
        begin
            tokens = $urandom_range(1, 8);
            for (t = 0; t < tokens; t++)
                str = {str, (($urandom_range(0, 5) == 0) ? CH_BACKSLASH
                                                         : 8'($urandom_range(0, 255)))};
        end
        else
        begin
            tokens = $urandom_range(1, 5);
            for (t = 0; t < tokens; t++)
            begin
                kind = token_t'($urandom_range(0, 4));
                case (kind)
                    TOK_OCT:
                        str = {str, CH_BACKSLASH, oct_char(), oct_char(), oct_char()};
                    TOK_HEX:
                        str = {str, CH_BACKSLASH, CH_HEX_MARK,
                               hex_char($urandom_range(0, 15)), hex_char($urandom_range(0, 15))};
                    TOK_BROKEN:
                    begin
                        if ($urandom_range(0, 1))
                            esc = {CH_BACKSLASH, oct_char(), oct_char()};
                        else
                            esc = {CH_BACKSLASH, CH_HEX_MARK, hex_char($urandom_range(0, 15))};
                        cut = $urandom_range(1, 3);
                        for (int i = 0; i < cut; i++)
                            str = {str, esc[i]};
                        if ($urandom_range(0, 1))
                            str = {str, 8'($urandom_range(0, 255))};
                    end
                    TOK_RAW:
                        str = {str, 8'($urandom_range(0, 255))};
                    default:
                        str = {str, CH_BACKSLASH};
                endcase
            end
        end
        queue_string(str);
    endtask

    // Sender: bursts of back-to-back words separated by random gaps.
    always @(negedge clk)
    begin
        dec_word_t w;
        if (rst_n && (!push || in_acc))
        begin
            if (gap_left > 0)
            begin
                push <= 1'b0;
                gap_left--;
            end
            else if (stim_q.size() > 0)
            begin
                w = stim_q.pop_front();
                push    <= 1'b1;
                in_byte <= w.val;
                in_last <= w.eos;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver: pop pattern switches between drain styles.
    always @(negedge clk)
    begin
        if (pace_left == 0)
        begin
            pace_mode = drain_mode_t'($urandom_range(0, 3));
            pace_left = $urandom_range(16, 96);
        end
        else
            pace_left--;
        beat++;
        case (pace_mode)
            DRAIN_FULL:    pop <= 1'b1;
            DRAIN_COIN:    pop <= 1'($urandom_range(0, 1));
            DRAIN_TRICKLE: pop <= ($urandom_range(0, 7) == 0);
            default:       pop <= (beat % 5 != 0);
        endcase
    end

    // Check results, predict from accepted words, watch for a hang.
    always @(posedge clk)
    begin
        dec_word_t want;
        bit        moved;
        moved = 1'b0;
        if (rst_n && pop && !empty)
        begin
            moved = 1'b1;
            if (decoded_q.size() == 0)
                flag_mismatch($sformatf("unexpected word byte=%02h last=%0b",
                                        out_byte, out_last));
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.val)
                    flag_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.val));
                if (out_last !== want.eos)
                    flag_mismatch($sformatf("out_last %0b, expected %0b", out_last, want.eos));
            end
        end
        in_acc = rst_n && push && !full;
        if (in_acc)
        begin
            moved = 1'b1;
            unescape_word(in_byte, in_last);
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("backslash_escape_decoder verification failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        // octal wrap, hex both cases, upper X raw, truncated escape at end
        queue_string('{CH_BACKSLASH, CH_OCT_MAX, CH_OCT_MAX, CH_OCT_MAX});
        queue_string('{CH_BACKSLASH, CH_HEX_MARK, CH_LC_A, CH_UC_F});
        queue_string('{CH_BACKSLASH, CH_UC_X, CH_ZERO + 8'd4});
        queue_string('{CH_BACKSLASH, CH_HEX_MARK, CH_ZERO + 8'd4});
        // short string at byte extremes
        queue_string('{8'h00, 8'hFF});
        // octal zero followed by a lone backslash at end
        queue_string('{CH_BACKSLASH, CH_ZERO, CH_ZERO, CH_ZERO, CH_BACKSLASH});
        // doubled backslash: first goes out raw, second starts an escape
        queue_string('{CH_BACKSLASH, CH_BACKSLASH, CH_ZERO + 8'd1, CH_ZERO, CH_ZERO + 8'd1});
        r = stim_q.size();
        while (stim_q.size() < r + RANDOM)
            queue_random_string();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_q.size() > 0 || push || decoded_q.size() > 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (errors == 0)
            $display("backslash_escape_decoder verification clean");
        else
            $display("backslash_escape_decoder verification failed");
        $finish;
    end

endmodule

// ----- backslash_escape_decoder.f -----
rtl/bed_pkg.sv
rtl/bed_fifo.sv
rtl/bed_front.sv
rtl/bed_back.sv
rtl/backslash_escape_decoder.sv
tb/backslash_escape_decoder_tb.sv
